FILE: sv/cbrw_pkg.sv
// ----------------------------------------------------------------------------
// cbrw_pkg
// Shared types, window constants and flush helper for the byte run combiner.
// ----------------------------------------------------------------------------
package cbrw_pkg;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_WINDOW   = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam logic [2:0] WIDTH_NONE = 3'd0;
    localparam logic [2:0] WIDTH_ONE  = 3'd1;
    localparam logic [2:0] WIDTH_TWO  = 3'd2;
    localparam logic [2:0] WIDTH_FOUR = 3'd4;

    localparam logic [31:0] WRAM_HIGH = 32'h0003_FFFF;
    localparam logic [31:0] WRAM_BASE = 32'h0200_0000;
    localparam logic [31:0] IRAM_LOW  = 32'h0004_0000;
    localparam logic [31:0] IRAM_HIGH = 32'h0004_7FFF;
    localparam logic [31:0] IRAM_BASE = 32'h0300_0000;
    localparam logic [31:0] IO_LOW    = 32'h0008_0000;
    localparam logic [31:0] IO_HIGH   = 32'h0008_03FF;
    localparam logic [31:0] IO_BASE   = 32'h0400_0000;

    // result queue entries, a power of two
    localparam int RESULT_DEPTH = 8;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] value;
        logic [2:0]  width;
        logic [1:0]  error;
        logic        last;
    } t_result;

    // up to two results from closing a segment
    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_flush;

    // all results caused by one input beat
    typedef struct packed {
        logic [1:0] count;
        t_result    res2;
        t_result    res1;
        t_result    res0;
    } t_burst;

    localparam t_result RESULT_EMPTY = '{address: 32'd0, value: 32'd0,
                                         width: WIDTH_NONE, error: ERR_NONE,
                                         last: 1'b0};

    function automatic t_flush flush_results(input logic [23:0] bytes,
                                             input logic [1:0]  cnt,
                                             input logic [31:0] end_addr);
        t_flush      f;
        logic [31:0] start;
        start = end_addr - {30'd0, cnt};
        f.count = 2'd0;
        f.res0  = RESULT_EMPTY;
        f.res1  = RESULT_EMPTY;
        case (cnt)
            2'd1: begin
                f.count         = 2'd1;
                f.res0.address  = start;
                f.res0.value    = {24'd0, bytes[7:0]};
                f.res0.width    = WIDTH_ONE;
            end
            2'd2: begin
                f.count         = 2'd1;
                f.res0.address  = start;
                f.res0.value    = {16'd0, bytes[15:0]};
                f.res0.width    = WIDTH_TWO;
            end
            2'd3: begin
                f.count         = 2'd2;
                f.res0.address  = start;
                f.res0.value    = {16'd0, bytes[15:0]};
                f.res0.width    = WIDTH_TWO;
                f.res1.address  = start + 32'd2;
                f.res1.value    = {24'd0, bytes[23:16]};
                f.res1.width    = WIDTH_ONE;
            end
            default: begin
                f.count = 2'd0;
            end
        endcase
        return f;
    endfunction

endpackage

FILE: sv/cbrw_core.sv
// ----------------------------------------------------------------------------
// cbrw_core
// Input register, address mapping and segment packing; emits one burst of
// up to three results per input beat.
// ----------------------------------------------------------------------------
module cbrw_core
    import cbrw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first_of_run,
    input  logic [31:0] i_run_address,
    input  logic        i_condition_mode,
    input  logic        i_last_of_run,
    input  logic        i_space,
    output logic        o_burst_valid,
    output t_burst      o_burst
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_first;
    logic [31:0] r_start;
    logic        r_cond;
    logic        r_last;

    logic [32:0] r_next_compact, n_next_compact;
    logic [31:0] r_expected_full, n_expected_full;
    logic [23:0] r_pending_bytes, n_pending_bytes;
    logic [1:0]  r_pending_count, n_pending_count;
    logic        r_run_condition, n_run_condition;
    logic        r_segment_open, n_segment_open;
    logic        r_discarding, n_discarding;

    logic        fire;
    logic        active;
    logic        cond;
    logic        seg;
    logic [32:0] addr;
    logic [31:0] lo;
    logic        in_wram, in_iram, in_io;
    logic [1:0]  err;
    logic [31:0] full;
    logic        preflush;
    t_flush      pre;
    t_flush      post;
    logic [1:0]  pc;
    logic [23:0] pb;
    logic [23:0] new_pb;
    logic [1:0]  new_pc;
    t_burst      burst;

    assign fire          = r_in_valid && i_space;
    assign o_ready       = !r_in_valid || fire;
    assign o_burst_valid = fire;
    assign o_burst       = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte  <= i_byte_value;
            r_first <= i_first_of_run;
            r_start <= i_run_address;
            r_cond  <= i_condition_mode;
            r_last  <= i_last_of_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_compact  <= '0;
            r_expected_full <= '0;
            r_pending_bytes <= '0;
            r_pending_count <= '0;
            r_run_condition <= 1'b0;
            r_segment_open  <= 1'b0;
            r_discarding    <= 1'b0;
        end else if (fire) begin
            r_next_compact  <= n_next_compact;
            r_expected_full <= n_expected_full;
            r_pending_bytes <= n_pending_bytes;
            r_pending_count <= n_pending_count;
            r_run_condition <= n_run_condition;
            r_segment_open  <= n_segment_open;
            r_discarding    <= n_discarding;
        end
    end

    // address mapping
    always_comb begin
        addr    = r_first ? {1'b0, r_start} : r_next_compact;
        cond    = r_first ? r_cond : r_run_condition;
        seg     = r_first ? 1'b0 : r_segment_open;
        active  = r_first || !r_discarding;
        lo      = addr[31:0];
        in_wram = (lo <= WRAM_HIGH);
        in_iram = (lo >= IRAM_LOW) && (lo <= IRAM_HIGH);
        in_io   = cond && (lo >= IO_LOW) && (lo <= IO_HIGH);
        if (addr[32]) begin
            err = ERR_OVERFLOW;
        end else if (in_wram || in_iram || in_io) begin
            err = ERR_NONE;
        end else begin
            err = ERR_WINDOW;
        end
        if (in_wram) begin
            full = WRAM_BASE + lo;
        end else if (in_iram) begin
            full = IRAM_BASE + (lo - IRAM_LOW);
        end else begin
            full = IO_BASE + (lo - IO_LOW);
        end
    end

    // segment packing and state update
    always_comb begin
        preflush = r_first ||
                   (active && ((err != ERR_NONE) || !seg || (full != r_expected_full)));
        pre = flush_results(r_pending_bytes, preflush ? r_pending_count : 2'd0,
                            r_expected_full);
        pc  = preflush ? 2'd0 : r_pending_count;
        pb  = preflush ? 24'd0 : r_pending_bytes;

        case (pc)
            2'd0:    new_pb = {16'd0, r_byte};
            2'd1:    new_pb = {8'd0, r_byte, pb[7:0]};
            default: new_pb = {r_byte, pb[15:0]};
        endcase
        new_pc = pc + 2'd1;

        post            = '0;
        post.res0       = RESULT_EMPTY;
        post.res1       = RESULT_EMPTY;
        n_next_compact  = addr;
        n_expected_full = r_expected_full;
        n_pending_bytes = pb;
        n_pending_count = pc;
        n_run_condition = cond;
        n_segment_open  = seg;
        n_discarding    = !active;

        if (active) begin
            if (err != ERR_NONE) begin
                post.count        = 2'd1;
                post.res0.address = lo;
                post.res0.error   = err;
                n_pending_bytes   = '0;
                n_pending_count   = '0;
                n_segment_open    = 1'b0;
                n_discarding      = 1'b1;
            end else begin
                n_expected_full = full + 32'd1;
                n_next_compact  = addr + 33'd1;
                n_segment_open  = !r_last;
                if (pc == 2'd3) begin
                    post.count        = 2'd1;
                    post.res0.address = full - 32'd3;
                    post.res0.value   = {r_byte, pb};
                    post.res0.width   = WIDTH_FOUR;
                    n_pending_bytes   = '0;
                    n_pending_count   = '0;
                end else if (r_last) begin
                    post            = flush_results(new_pb, new_pc, full + 32'd1);
                    n_pending_bytes = '0;
                    n_pending_count = '0;
                end else begin
                    n_pending_bytes = new_pb;
                    n_pending_count = new_pc;
                end
            end
        end

        burst.count = pre.count + post.count;
        burst.res0  = (pre.count != 2'd0) ? pre.res0 : post.res0;
        case (pre.count)
            2'd2: begin
                burst.res1 = pre.res1;
                burst.res2 = post.res0;
            end
            2'd1: begin
                burst.res1 = post.res0;
                burst.res2 = post.res1;
            end
            default: begin
                burst.res1 = post.res1;
                burst.res2 = RESULT_EMPTY;
            end
        endcase
        case (burst.count)
            2'd1:    burst.res0.last = 1'b1;
            2'd2:    burst.res1.last = 1'b1;
            2'd3:    burst.res2.last = 1'b1;
            default: burst.res0.last = burst.res0.last;
        endcase
    end

endmodule

FILE: sv/cbrw_result_fifo.sv
// ----------------------------------------------------------------------------
// cbrw_result_fifo
// Result queue: takes a burst of up to three results per cycle, hands out
// one result per output beat.
// ----------------------------------------------------------------------------
module cbrw_result_fifo
    import cbrw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_burst  i_burst,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int PTR_W = $clog2(RESULT_DEPTH);
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    t_result            r_mem [RESULT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   push_n;
    logic               pop;

    assign o_space  = (r_count <= CNT_W'(RESULT_DEPTH - 3));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    always_comb begin
        push_n   = i_push ? CNT_W'(i_burst.count) : '0;
        n_wr_ptr = r_wr_ptr + PTR_W'(push_n);
        n_rd_ptr = pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + push_n - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_burst.count >= 2'd1) begin
                r_mem[r_wr_ptr] <= i_burst.res0;
            end
            if (i_burst.count >= 2'd2) begin
                r_mem[r_wr_ptr + PTR_W'(1)] <= i_burst.res1;
            end
            if (i_burst.count == 2'd3) begin
                r_mem[r_wr_ptr + PTR_W'(2)] <= i_burst.res2;
            end
        end
    end

endmodule

FILE: sv/compact_byte_run_write_combiner_top.sv
// ----------------------------------------------------------------------------
// compact_byte_run_write_combiner_top
// Maps byte runs at compact addresses into bus windows and packs contiguous
// bytes into little-endian writes of 4, 2 and 1 bytes.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    byte, run flags, run address
//   result   out        o_valid / i_ready    write address, value, width, error
//
// one input beat per cycle unless stalled; each beat is registered, then packed
// into a burst of zero to three results pushed into an eight-entry result queue
// the input side stalls only while the queue has fewer than three free slots
// results leave one per output beat; each passes the input register, then the queue
// synchronous active-low reset clears run state and empties the queue
// ----------------------------------------------------------------------------
module compact_byte_run_write_combiner_top
    import cbrw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first_of_run,
    input  logic [31:0] i_run_address,
    input  logic        i_condition_mode,
    input  logic        i_last_of_run,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_write_address,
    output logic [31:0] o_write_value,
    output logic [2:0]  o_write_width,
    output logic [1:0]  o_error_code,
    output logic        o_last_result
);

    logic    space;
    logic    burst_valid;
    t_burst  burst;
    t_result result;

    cbrw_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_byte_value     (i_byte_value),
        .i_first_of_run   (i_first_of_run),
        .i_run_address    (i_run_address),
        .i_condition_mode (i_condition_mode),
        .i_last_of_run    (i_last_of_run),
        .i_space          (space),
        .o_burst_valid    (burst_valid),
        .o_burst          (burst)
    );

    cbrw_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (burst_valid),
        .i_burst  (burst),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_write_address = result.address;
    assign o_write_value   = result.value;
    assign o_write_width   = result.width;
    assign o_error_code    = result.error;
    assign o_last_result   = result.last;

endmodule

FILE: dv/compact_byte_run_write_combiner_top_test.sv
// ----------------------------------------------------------------------------
// compact_byte_run_write_combiner_top_test
// Drives byte runs into the combiner through its valid/ready input and checks
// every write and error beat against a cycle-free model of the address
// windows and the 4/2/1 byte packing. A short directed opening covers window
// edges, errors, stray bytes and segment flushes. Random runs then follow
// under changing sender and receiver idle rates and a long receiver stall.
// ----------------------------------------------------------------------------
module compact_byte_run_write_combiner_top_test;
    import cbrw_pkg::*;

    class write_predictor;
        logic [32:0] next_compact;
        logic [31:0] expected_full;
        logic [23:0] pending_bytes;
        logic [1:0]  pending_count;
        logic        run_condition;
        logic        segment_open;
        logic        discarding;
        t_result     burst[$];
        t_result     due_writes[$];
        int          mismatches;

        function new();
            next_compact  = '0;
            expected_full = '0;
            pending_bytes = '0;
            pending_count = '0;
            run_condition = 1'b0;
            segment_open  = 1'b0;
            discarding    = 1'b0;
            mismatches    = 0;
        endfunction

        function int outstanding();
            return due_writes.size();
        endfunction

        function void add(input logic [31:0] address, input logic [31:0] value,
                          input logic [2:0] width, input logic [1:0] code);
            t_result r;
            r.address = address;
            r.value   = value;
            r.width   = width;
            r.error   = code;
            r.last    = 1'b0;
            burst = {burst, r};
        endfunction

        function void close_segment();
            logic [31:0] base;
            base = expected_full - {30'd0, pending_count};
            case (pending_count)
                2'd1: add(base, {24'd0, pending_bytes[7:0]}, WIDTH_ONE, ERR_NONE);
                2'd2: add(base, {16'd0, pending_bytes[15:0]}, WIDTH_TWO, ERR_NONE);
                2'd3: begin
                    add(base, {16'd0, pending_bytes[15:0]}, WIDTH_TWO, ERR_NONE);
                    add(base + 32'd2, {24'd0, pending_bytes[23:16]}, WIDTH_ONE, ERR_NONE);
                end
                default: ;
            endcase
            pending_count = '0;
            pending_bytes = '0;
        endfunction

        // 1 when the compact address lands in a window
        function bit window_of(input logic [31:0] a, input logic cond,
                               output logic [31:0] full);
            full = '0;
            if (a <= WRAM_HIGH) begin
                full = WRAM_BASE + a;
                return 1'b1;
            end
            if (a >= IRAM_LOW && a <= IRAM_HIGH) begin
                full = IRAM_BASE + (a - IRAM_LOW);
                return 1'b1;
            end
            if (cond && a >= IO_LOW && a <= IO_HIGH) begin
                full = IO_BASE + (a - IO_LOW);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(input logic [7:0] data, input logic first,
                                input logic [31:0] start, input logic cond,
                                input logic last);
            logic [31:0] full;
            logic [1:0]  code;
            burst.delete();
            full = '0;
            if (first) begin
                close_segment();
                segment_open  = 1'b0;
                next_compact  = {1'b0, start};
                run_condition = cond;
                discarding    = 1'b0;
            end
            if (!discarding) begin
                code = ERR_NONE;
                if (next_compact[32])
                    code = ERR_OVERFLOW;
                else if (!window_of(next_compact[31:0], run_condition, full))
                    code = ERR_WINDOW;
                if (code != ERR_NONE) begin
                    close_segment();
                    add(next_compact[31:0], 32'd0, WIDTH_NONE, code);
                    segment_open = 1'b0;
                    discarding   = 1'b1;
                end else begin
                    if (!segment_open || full != expected_full) begin
                        close_segment();
                        segment_open = 1'b1;
                    end
                    if (pending_count == 2'd3) begin
                        add(full - 32'd3, {data, pending_bytes}, WIDTH_FOUR, ERR_NONE);
                        pending_count = '0;
                        pending_bytes = '0;
                    end else begin
                        pending_bytes[8*pending_count +: 8] = data;
                        pending_count = pending_count + 2'd1;
                    end
                    expected_full = full + 32'd1;
                    next_compact  = next_compact + 33'd1;
                    if (last) begin
                        close_segment();
                        segment_open = 1'b0;
                    end
                end
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                due_writes = {due_writes, burst[i]};
        endfunction

        function bit compare_field(input string name, input logic [31:0] e,
                                   input logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s expected %h actual %h", $time, name, e, a);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_write(input t_result got);
            t_result exp;
            bit      ok;
            if (due_writes.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual addr %h value %h",
                         $time, got.address, got.value);
                mismatches++;
                return;
            end
            exp = due_writes.pop_front();
            ok = 1'b1;
            ok &= compare_field("write_address", exp.address, got.address);
            ok &= compare_field("write_value", exp.value, got.value);
            ok &= compare_field("write_width", {29'd0, exp.width}, {29'd0, got.width});
            ok &= compare_field("error_code", {30'd0, exp.error}, {30'd0, got.error});
            ok &= compare_field("last_result", {31'd0, exp.last}, {31'd0, got.last});
            if (!ok)
                mismatches++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_byte_value = '0;
    logic        i_first_of_run = 1'b0;
    logic [31:0] i_run_address = '0;
    logic        i_condition_mode = 1'b0;
    logic        i_last_of_run = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_write_address;
    logic [31:0] o_write_value;
    logic [2:0]  o_write_width;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    int tx_idle_pct = 36;
    int rx_idle_pct = 73;
    int rx_hold_left = 0;
    int beats_sent = 0;

    write_predictor predictor;

    compact_byte_run_write_combiner_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_byte_value     (i_byte_value),
        .i_first_of_run   (i_first_of_run),
        .i_run_address    (i_run_address),
        .i_condition_mode (i_condition_mode),
        .i_last_of_run    (i_last_of_run),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_write_address  (o_write_address),
        .o_write_value    (o_write_value),
        .o_write_width    (o_write_width),
        .o_error_code     (o_error_code),
        .o_last_result    (o_last_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver ready, with an optional long hold
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_ready = 1'b0;
            rx_hold_left--;
        end else begin
            i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        got.address = o_write_address;
        got.value   = o_write_value;
        got.width   = o_write_width;
        got.error   = o_error_code;
        got.last    = o_last_result;
        if (i_rst_n && o_valid && i_ready)
            predictor.check_write(got);
    end

    task automatic send_byte(input logic [7:0] data, input logic first,
                             input logic [31:0] start, input logic cond,
                             input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_byte_value     = data;
        i_first_of_run   = first;
        i_run_address    = start;
        i_condition_mode = cond;
        i_last_of_run    = last;
        do @(posedge i_clk); while (!o_ready);
        predictor.note_byte(data, first, start, cond, last);
        beats_sent++;
    endtask

    // address and flag on non-first beats are don't-care, so randomize them
    task automatic send_run(input logic [31:0] start, input logic cond, input int len,
                            input bit with_first, input bit with_last);
        logic first;
        logic last;
        for (int k = 0; k < len; k++) begin
            first = with_first && (k == 0);
            last  = with_last && (k == len - 1);
            send_byte(8'($urandom_range(0, 255)), first, first ? start : $urandom(),
                      first ? cond : 1'($urandom_range(0, 1)), last);
        end
    endtask

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(0, WRAM_HIGH);
            2: return WRAM_HIGH - $urandom_range(0, 12);
            3: return $urandom_range(IRAM_LOW, IRAM_HIGH);
            4: return IRAM_HIGH - $urandom_range(0, 12);
            5: return $urandom_range(IO_LOW, IO_HIGH);
            6: return IO_HIGH - $urandom_range(0, 12);
            7: return $urandom_range(0, 8);
            8: return $urandom_range(0, 1) ? IO_LOW - $urandom_range(0, 2)
                                           : IRAM_LOW - $urandom_range(0, 2);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_runs(input int target);
        int kind;
        int len;
        while (beats_sent < target) begin
            kind = $urandom_range(0, 19);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                               : $urandom_range(1, 9);
            if (kind < 16)
                send_run(pick_start(), $urandom_range(0, 3) != 0, len, 1'b1, 1'b1);
            else if (kind < 18)
                send_run(pick_start(), $urandom_range(0, 3) != 0, len, 1'b1, 1'b0);
            else
                send_run(32'd0, 1'b0, len, 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (predictor.outstanding() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        #1000000;
        $display("compact_byte_run_write_combiner_top_test: done, errors");
        $finish;
    end

    initial begin
        predictor = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // stray bytes straight after reset
        send_byte(8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 32'd0, 1'b1, 1'b1);
        // work ram into internal ram, discontinuity
        send_run(WRAM_HIGH - 32'd1, 1'b0, 4, 1'b1, 1'b1);
        // run off the end of internal ram, rest dropped
        send_run(IRAM_HIGH - 32'd1, 1'b0, 4, 1'b1, 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom(), 1'b1, 1'b1);
        // i/o window without condition mode
        send_run(IO_LOW, 1'b0, 1, 1'b1, 1'b1);
        // full word then off the end of the i/o window
        send_run(IO_HIGH - 32'd3, 1'b1, 5, 1'b1, 1'b1);
        // open segment flushed by next run, no join across runs
        send_run(32'd0, 1'b1, 3, 1'b1, 1'b0);
        send_run(32'd3, 1'b1, 2, 1'b1, 1'b1);
        send_run(32'hFFFF_FFFF, 1'b1, 1, 1'b1, 1'b1);
        // stray byte continuing a finished run
        send_run(IRAM_LOW, 1'b1, 2, 1'b1, 1'b1);
        send_byte(8'h5A, 1'b0, 32'd0, 1'b0, 1'b1);

        random_runs(140);
        drain();
        tx_idle_pct = 73;
        rx_idle_pct = 36;
        random_runs(255);
        drain();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 300;
        random_runs(370);
        @(negedge i_clk);
        i_valid = 1'b0;
        drain();
        repeat (16) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.outstanding() == 0) begin
            $display("compact_byte_run_write_combiner_top_test: done, clean");
        end else begin
            $display("compact_byte_run_write_combiner_top_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/cbrw_pkg.sv
sv/cbrw_core.sv
sv/cbrw_result_fifo.sv
sv/compact_byte_run_write_combiner_top.sv
dv/compact_byte_run_write_combiner_top_test.sv
